@@ rtl/jtsc_pkg.sv @@
`timescale 1ns / 1ps

package jtsc_pkg;

    localparam int TK_W  = 4;
    localparam int ST_W  = 2;
    localparam int CA_W  = 2;
    localparam int DEP_W = 7;
    localparam int NX_W  = 3;

    localparam int MAX_DEPTH_DEF = 64;
    localparam logic [DEP_W-1:0] LIMIT_RESET = 7'd64;

    // token kinds on the input channel
    localparam logic [TK_W-1:0] TK_END        = 4'd0;
    localparam logic [TK_W-1:0] TK_OPEN_OBJ   = 4'd1;
    localparam logic [TK_W-1:0] TK_CLOSE_OBJ  = 4'd2;
    localparam logic [TK_W-1:0] TK_OPEN_ARR   = 4'd3;
    localparam logic [TK_W-1:0] TK_CLOSE_ARR  = 4'd4;
    localparam logic [TK_W-1:0] TK_COLON      = 4'd5;
    localparam logic [TK_W-1:0] TK_COMMA      = 4'd6;
    localparam logic [TK_W-1:0] TK_STRING     = 4'd7;
    localparam logic [TK_W-1:0] TK_NUMBER     = 4'd8;
    localparam logic [TK_W-1:0] TK_BOOLEAN    = 4'd9;
    localparam logic [TK_W-1:0] TK_NULL       = 4'd10;

    // result status
    localparam logic [ST_W-1:0] ST_TOKEN_OK = 2'd0;
    localparam logic [ST_W-1:0] ST_DOC_OK   = 2'd1;
    localparam logic [ST_W-1:0] ST_DOC_BAD  = 2'd2;
    localparam logic [ST_W-1:0] ST_ERROR    = 2'd3;

    // error causes
    localparam logic [CA_W-1:0] CA_NONE    = 2'd0;
    localparam logic [CA_W-1:0] CA_BAD_TOK = 2'd1;
    localparam logic [CA_W-1:0] CA_DEEP    = 2'd2;
    localparam logic [CA_W-1:0] CA_EARLY   = 2'd3;

    // token class allowed next
    localparam logic [NX_W-1:0] NX_VALUE          = 3'd0;
    localparam logic [NX_W-1:0] NX_VALUE_OR_CLOSE = 3'd1;
    localparam logic [NX_W-1:0] NX_KEY_OR_CLOSE   = 3'd2;
    localparam logic [NX_W-1:0] NX_KEY            = 3'd3;
    localparam logic [NX_W-1:0] NX_COLON          = 3'd4;
    localparam logic [NX_W-1:0] NX_COMMA_OR_CLOSE = 3'd5;
    localparam logic [NX_W-1:0] NX_DONE           = 3'd6;

    typedef enum logic [3:0] {
        C_END,
        C_OPEN_OBJ,
        C_CLOSE_OBJ,
        C_OPEN_ARR,
        C_CLOSE_ARR,
        C_COLON,
        C_COMMA,
        C_STRING,
        C_SCALAR,
        C_BAD
    } t_cls;

    typedef struct packed {
        logic valid;
        t_cls cls;
    } t_qitem;

endpackage

@@ rtl/jtsc_tok_if.sv @@
`timescale 1ns / 1ps

interface jtsc_tok_if;
    logic                       valid;
    logic                       ready;
    logic [jtsc_pkg::TK_W-1:0]  token_kind;

    modport source (output valid, output token_kind, input ready);
    modport sink   (input valid, input token_kind, output ready);
endinterface

@@ rtl/jtsc_res_if.sv @@
`timescale 1ns / 1ps

interface jtsc_res_if;
    logic                       valid;
    logic                       ready;
    logic [jtsc_pkg::ST_W-1:0]  status;
    logic [jtsc_pkg::CA_W-1:0]  error_cause;
    logic [jtsc_pkg::DEP_W-1:0] nesting_depth;

    modport source (output valid, output status, output error_cause,
                    output nesting_depth, input ready);
    modport sink   (input valid, input status, input error_cause,
                    input nesting_depth, output ready);
endinterface

@@ rtl/jtsc_cfg_if.sv @@
`timescale 1ns / 1ps

interface jtsc_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [jtsc_pkg::DEP_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/jtsc_front.sv @@
`timescale 1ns / 1ps

module jtsc_front (
    jtsc_tok_if.sink            i_tok,
    input  logic                i_q_full,
    output jtsc_pkg::t_qitem    o_push
);
    import jtsc_pkg::*;

    t_cls cls;

    always_comb begin
        case (i_tok.token_kind)
            TK_END:                         cls = C_END;
            TK_OPEN_OBJ:                    cls = C_OPEN_OBJ;
            TK_CLOSE_OBJ:                   cls = C_CLOSE_OBJ;
            TK_OPEN_ARR:                    cls = C_OPEN_ARR;
            TK_CLOSE_ARR:                   cls = C_CLOSE_ARR;
            TK_COLON:                       cls = C_COLON;
            TK_COMMA:                       cls = C_COMMA;
            TK_STRING:                      cls = C_STRING;
            TK_NUMBER, TK_BOOLEAN, TK_NULL: cls = C_SCALAR;
            default:                        cls = C_BAD;
        endcase
    end

    assign i_tok.ready  = ~i_q_full;
    assign o_push.valid = i_tok.valid & ~i_q_full;
    assign o_push.cls   = cls;

endmodule

@@ rtl/jtsc_queue.sv @@
`timescale 1ns / 1ps

module jtsc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  jtsc_pkg::t_qitem    i_push,
    output logic                o_full,
    input  logic                i_pop,
    output jtsc_pkg::t_qitem    o_head
);
    import jtsc_pkg::*;

    // two entries: enough for full rate with a registered consumer
    t_cls       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign do_push = i_push.valid;
    assign do_pop  = i_pop & (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_push.cls;
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cls   = r_mem[r_rp];

endmodule

@@ rtl/jtsc_ram.sv @@
`timescale 1ns / 1ps

module jtsc_ram #(
    parameter int WIDTH  = 1,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/jtsc_back.sv @@
`timescale 1ns / 1ps

module jtsc_back #(
    parameter int MAX_DEPTH = jtsc_pkg::MAX_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  jtsc_pkg::t_qitem    i_head,
    output logic                o_pop,
    jtsc_cfg_if.sink            i_cfg,
    jtsc_res_if.source          o_res
);
    import jtsc_pkg::*;

    localparam int AW      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CNT_MAX = (1 << DEP_W) - 1;
    localparam int LIM_CAP = (MAX_DEPTH > CNT_MAX) ? CNT_MAX : MAX_DEPTH;

    logic [DEP_W-1:0] r_limit;
    logic [DEP_W-1:0] r_count, n_count;
    logic [NX_W-1:0]  r_next, n_next;
    logic             r_err, n_err;
    logic [CA_W-1:0]  r_cause, n_cause;
    logic             r_top, n_top;     // innermost container, 1 = object
    logic             r_fwd;            // last cycle wrote the entry now read
    logic             r_fwd_data;

    logic             r_out_valid;
    logic [ST_W-1:0]  r_status;
    logic [CA_W-1:0]  r_ecause;
    logic [DEP_W-1:0] r_depth;

    logic [DEP_W-1:0] lim;
    logic             advance, top_obj, vexp, below, ram_q;
    logic             close_ok, a_push, wr_en;
    logic [DEP_W-1:0] a_count;
    logic [NX_W-1:0]  a_next;
    logic             a_top;
    logic [CA_W-1:0]  a_cause, res_cause;
    logic [ST_W-1:0]  res_status;
    logic [DEP_W-1:0] rd_idx, wr_idx;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_limit <= LIMIT_RESET;
        else if (i_cfg.valid) r_limit <= i_cfg.data;
    end

    assign lim     = (r_limit > DEP_W'(LIM_CAP)) ? DEP_W'(LIM_CAP) : r_limit;
    assign advance = i_head.valid & (~r_out_valid | o_res.ready);
    assign o_pop   = advance;
    assign top_obj = (r_count != '0) & r_top;
    assign vexp    = (r_next == NX_VALUE) | (r_next == NX_VALUE_OR_CLOSE);
    assign below   = r_fwd ? r_fwd_data : ram_q;

    // token rules, evaluated against the current state
    always_comb begin
        a_count  = r_count;
        a_next   = r_next;
        a_top    = r_top;
        a_push   = 1'b0;
        a_cause  = CA_NONE;
        close_ok = 1'b0;
        case (i_head.cls)
            C_OPEN_OBJ, C_OPEN_ARR: begin
                if (!vexp) begin
                    a_cause = CA_BAD_TOK;
                end else if (r_count >= lim) begin
                    a_cause = CA_DEEP;
                end else begin
                    a_count = r_count + 7'd1;
                    a_top   = (i_head.cls == C_OPEN_OBJ);
                    a_next  = (i_head.cls == C_OPEN_OBJ) ? NX_KEY_OR_CLOSE
                                                         : NX_VALUE_OR_CLOSE;
                    a_push  = 1'b1;
                end
            end
            C_CLOSE_OBJ, C_CLOSE_ARR: begin
                if (i_head.cls == C_CLOSE_OBJ)
                    close_ok = (r_next == NX_KEY_OR_CLOSE) |
                               ((r_next == NX_COMMA_OR_CLOSE) & top_obj);
                else
                    close_ok = (r_next == NX_VALUE_OR_CLOSE) |
                               ((r_next == NX_COMMA_OR_CLOSE) & (r_count != '0) &
                                ~top_obj);
                if (!close_ok || r_count == '0) begin
                    a_cause = CA_BAD_TOK;
                end else begin
                    a_count = r_count - 7'd1;
                    a_top   = below;
                    a_next  = (r_count == 7'd1) ? NX_DONE : NX_COMMA_OR_CLOSE;
                end
            end
            C_COLON: begin
                if (r_next != NX_COLON) a_cause = CA_BAD_TOK;
                else a_next = NX_VALUE;
            end
            C_COMMA: begin
                if (r_next != NX_COMMA_OR_CLOSE) a_cause = CA_BAD_TOK;
                else a_next = top_obj ? NX_KEY : NX_VALUE;
            end
            C_STRING: begin
                if (r_next == NX_KEY || r_next == NX_KEY_OR_CLOSE) begin
                    a_next = NX_COLON;
                end else if (!vexp) begin
                    a_cause = CA_BAD_TOK;
                end else begin
                    a_next = (r_count == '0) ? NX_DONE : NX_COMMA_OR_CLOSE;
                end
            end
            C_SCALAR: begin
                if (!vexp) a_cause = CA_BAD_TOK;
                else a_next = (r_count == '0) ? NX_DONE : NX_COMMA_OR_CLOSE;
            end
            default: a_cause = CA_BAD_TOK;
        endcase
    end

    always_comb begin
        n_count    = r_count;
        n_next     = r_next;
        n_err      = r_err;
        n_cause    = r_cause;
        n_top      = r_top;
        res_status = ST_TOKEN_OK;
        res_cause  = CA_NONE;
        wr_en      = 1'b0;
        if (advance) begin
            if (i_head.cls == C_END) begin
                if (r_err) begin
                    res_status = ST_DOC_BAD;
                    res_cause  = r_cause;
                end else if (r_next == NX_DONE) begin
                    res_status = ST_DOC_OK;
                end else begin
                    res_status = ST_DOC_BAD;
                    res_cause  = CA_EARLY;
                end
                n_count = '0;
                n_next  = NX_VALUE;
                n_err   = 1'b0;
                n_cause = CA_NONE;
            end else if (r_err) begin
                res_status = ST_ERROR;
                res_cause  = r_cause;
            end else if (a_cause != CA_NONE) begin
                res_status = ST_ERROR;
                res_cause  = a_cause;
                n_err      = 1'b1;
                n_cause    = a_cause;
            end else begin
                n_count = a_count;
                n_next  = a_next;
                n_top   = a_top;
                wr_en   = a_push & (r_count != '0);
            end
        end
    end

    // stack below the top lives in RAM; keep the entry under the new top
    // prefetched so a pop can take it without a read stall
    assign rd_idx = (n_count >= 7'd2) ? (n_count - 7'd2) : '0;
    assign wr_idx = r_count - 7'd1;

    jtsc_ram #(
        .WIDTH (1),
        .DEPTH (MAX_DEPTH),
        .ADDR_W(AW)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(AW'(wr_idx)),
        .i_wdata(r_top),
        .i_raddr(AW'(rd_idx)),
        .o_rdata(ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_next      <= NX_VALUE;
            r_err       <= 1'b0;
            r_cause     <= CA_NONE;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_next  <= n_next;
            r_err   <= n_err;
            r_cause <= n_cause;
            r_fwd   <= wr_en;
            if (advance) r_out_valid <= 1'b1;
            else if (o_res.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top      <= n_top;
        r_fwd_data <= r_top;
        if (advance) begin
            r_status <= res_status;
            r_ecause <= res_cause;
            r_depth  <= n_count;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_status;
    assign o_res.error_cause   = r_ecause;
    assign o_res.nesting_depth = r_depth;

endmodule

@@ rtl/json_token_structure_check.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Handshake     Payload
// i_tok     in   valid/ready   token_kind[3:0]
// o_res     out  valid/ready   status[1:0], error_cause[1:0], nesting_depth[6:0]
// i_cfg     in   valid/ready   data[6:0] -> depth_limit (always ready)
//
// One token per cycle sustained while o_res is not stalled. Each result
// passes through the queue and then the checker's output register.
// The checker's rule table is combinational and works with a stack step;
// the entry beneath the stack top is prefetched from the RAM each cycle.
// Reset (synchronous, active low) clears control state at once; no
// clearing pass, the stack RAM is only read below the live depth.
// A stalled o_res holds the checker; the two-entry queue absorbs the input
// until it fills, then i_tok.ready drops.

module json_token_structure_check #(
    parameter int MAX_DEPTH = jtsc_pkg::MAX_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jtsc_tok_if.sink    i_tok,
    jtsc_cfg_if.sink    i_cfg,
    jtsc_res_if.source  o_res
);
    import jtsc_pkg::*;

    t_qitem push;
    t_qitem head;
    logic   q_full;
    logic   pop;

    // front: classify token kind, enqueue
    jtsc_front u_front (
        .i_tok   (i_tok),
        .i_q_full(q_full),
        .o_push  (push)
    );

    // decoupling queue between classifier and checker
    jtsc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_full (q_full),
        .i_pop  (pop),
        .o_head (head)
    );

    // back: structure state, nesting stack, result register
    jtsc_back #(
        .MAX_DEPTH(MAX_DEPTH)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_head (head),
        .o_pop  (pop),
        .i_cfg  (i_cfg),
        .o_res  (o_res)
    );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

// Testbench for json_token_structure_check.
// Token transactions go in on i_tok. Each one is run through a cycle-free
// copy of the structure rules held here: container stack, next-class code,
// sticky error and the depth limit. The verdict that copy gives is queued,
// and every result transaction on o_res is checked against the oldest entry.
// Depth limit writes on i_cfg only happen with nothing outstanding.

module testbench;
    import jtsc_pkg::*;

    localparam int MAXD          = MAX_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 4;        // drain margin after the last result
    localparam int RANDOM_ITEMS  = 90;       // per idling phase, four phases

    // no package names for these: unknown token, and the top of the unused codes
    localparam logic [TK_W-1:0] TK_UNKNOWN  = 4'd11;
    localparam logic [TK_W-1:0] TK_TOP_CODE = 4'd15;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [CA_W-1:0]  cause;
        logic [DEP_W-1:0] depth;
    } t_verdict;

    logic i_clk;
    logic i_rst_n;

    jtsc_tok_if tok_if ();
    jtsc_cfg_if cfg_if ();
    jtsc_res_if res_if ();

    json_token_structure_check u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (tok_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // ------------------------------------------------------------------
    // Structure state as the block should hold it
    // ------------------------------------------------------------------
    bit [MAXD-1:0]    kind_stack;     // 1 = object, 0 = array
    int unsigned      open_depth;
    logic [NX_W-1:0]  next_class;
    bit               err_flag;
    logic [CA_W-1:0]  err_cause;
    logic [DEP_W-1:0] depth_limit_r;

    t_verdict verdict_q[$];           // verdicts still owed by the block

    int fail_count;
    int tokens_sent;
    int idle_pct;                     // sender gap rate, percent
    int stall_pct;                    // receiver stall rate, percent

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void log_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch @%0t: %s", $realtime, msg);
    endfunction

    function automatic void clear_document();
        open_depth = 0;
        next_class = NX_VALUE;
        err_flag   = 1'b0;
        err_cause  = CA_NONE;
    endfunction

    function automatic bit top_is_object();
        if (open_depth == 0)
            return 1'b0;
        return kind_stack[open_depth-1];
    endfunction

    // Applies one token to the structure state. Returns the error cause,
    // CA_NONE when the token fits; an offending token leaves state alone.
    function automatic logic [CA_W-1:0] apply_token(input logic [TK_W-1:0] tk);
        int unsigned lim;
        bit          want_value;
        bit          close_ok;
        lim        = (depth_limit_r > MAXD) ? MAXD : depth_limit_r;
        want_value = (next_class == NX_VALUE) || (next_class == NX_VALUE_OR_CLOSE);
        case (tk)
            TK_OPEN_OBJ, TK_OPEN_ARR: begin
                if (!want_value)
                    return CA_BAD_TOK;
                if (open_depth >= lim)
                    return CA_DEEP;
                kind_stack[open_depth] = (tk == TK_OPEN_OBJ);
                open_depth++;
                next_class = (tk == TK_OPEN_OBJ) ? NX_KEY_OR_CLOSE : NX_VALUE_OR_CLOSE;
            end
            TK_CLOSE_OBJ, TK_CLOSE_ARR: begin
                // close must match the innermost container
                if (tk == TK_CLOSE_OBJ)
                    close_ok = (next_class == NX_KEY_OR_CLOSE) ||
                               (next_class == NX_COMMA_OR_CLOSE && top_is_object());
                else
                    close_ok = (next_class == NX_VALUE_OR_CLOSE) ||
                               (next_class == NX_COMMA_OR_CLOSE && open_depth != 0 &&
                                !top_is_object());
                if (!close_ok || open_depth == 0)
                    return CA_BAD_TOK;
                open_depth--;
                next_class = (open_depth == 0) ? NX_DONE : NX_COMMA_OR_CLOSE;
            end
            TK_COLON: begin
                if (next_class != NX_COLON)
                    return CA_BAD_TOK;
                next_class = NX_VALUE;
            end
            TK_COMMA: begin
                // inside an object a key must follow
                if (next_class != NX_COMMA_OR_CLOSE)
                    return CA_BAD_TOK;
                next_class = top_is_object() ? NX_KEY : NX_VALUE;
            end
            TK_STRING: begin
                if (next_class == NX_KEY || next_class == NX_KEY_OR_CLOSE) begin
                    next_class = NX_COLON;
                end else begin
                    if (!want_value)
                        return CA_BAD_TOK;
                    next_class = (open_depth == 0) ? NX_DONE : NX_COMMA_OR_CLOSE;
                end
            end
            TK_NUMBER, TK_BOOLEAN, TK_NULL: begin
                // a scalar at top level completes the document
                if (!want_value)
                    return CA_BAD_TOK;
                next_class = (open_depth == 0) ? NX_DONE : NX_COMMA_OR_CLOSE;
            end
            default: return CA_BAD_TOK;     // unknown and unused codes
        endcase
        return CA_NONE;
    endfunction

    function automatic t_verdict predict_token(input logic [TK_W-1:0] tk);
        t_verdict         v;
        logic [CA_W-1:0]  c;
        if (tk == TK_END) begin
            if (err_flag) begin
                v.status = ST_DOC_BAD;
                v.cause  = err_cause;
            end else if (next_class == NX_DONE) begin
                v.status = ST_DOC_OK;
                v.cause  = CA_NONE;
            end else begin
                v.status = ST_DOC_BAD;
                v.cause  = CA_EARLY;
            end
            clear_document();
        end else if (err_flag) begin
            // sticky: state frozen until the end token
            v.status = ST_ERROR;
            v.cause  = err_cause;
        end else begin
            c = apply_token(tk);
            if (c != CA_NONE) begin
                err_flag  = 1'b1;
                err_cause = c;
                v.status  = ST_ERROR;
            end else begin
                v.status  = ST_TOKEN_OK;
            end
            v.cause = c;
        end
        v.depth = DEP_W'(open_depth);
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the per-transaction check
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_verdict want;
        res_if.ready <= ($urandom_range(99) >= stall_pct);
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (verdict_q.size() == 0) begin
                log_mismatch("result transaction with no verdict outstanding");
            end else begin
                want = verdict_q.pop_front();
                if (res_if.status !== want.status || res_if.error_cause !== want.cause ||
                    res_if.nesting_depth !== want.depth)
                    log_mismatch($sformatf(
                        "status %0d exp %0d, cause %0d exp %0d, depth %0d exp %0d",
                        res_if.status, want.status, res_if.error_cause, want.cause,
                        res_if.nesting_depth, want.depth));
            end
        end
    end

    // ------------------------------------------------------------------
    // Token side
    // ------------------------------------------------------------------
    // Valid stays high into the next call unless a gap is drawn, so it is
    // never dropped and raised in one step.
    task automatic send_token(input logic [TK_W-1:0] tk);
        while ($urandom_range(99) < idle_pct) begin
            tok_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        tok_if.valid      <= 1'b1;
        tok_if.token_kind <= tk;
        do @(posedge i_clk); while (tok_if.ready !== 1'b1);
        verdict_q = {verdict_q, predict_token(tk)};
        tokens_sent++;
    endtask

    // Block idle: nothing outstanding, then let the pipeline empty.
    task automatic settle();
        tok_if.valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_depth_limit(input logic [DEP_W-1:0] lim);
        settle();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= lim;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid  <= 1'b0;
        depth_limit_r  = lim;
    endtask

    task automatic set_idling(input int src, input int snk);
        idle_pct  = src;
        stall_pct = snk;
    endtask

    // Draws a token that fits the next-class code, not the depth limit.
    // wind_down steers towards closing everything so the document finishes.
    function automatic logic [TK_W-1:0] pick_legal(input bit wind_down, input int open_pct);
        int              r;
        logic [TK_W-1:0] close_tk;
        logic [TK_W-1:0] scalar_tk;
        r        = $urandom_range(99);
        close_tk = top_is_object() ? TK_CLOSE_OBJ : TK_CLOSE_ARR;
        case ($urandom_range(3))
            0:       scalar_tk = TK_STRING;
            1:       scalar_tk = TK_NUMBER;
            2:       scalar_tk = TK_BOOLEAN;
            default: scalar_tk = TK_NULL;
        endcase
        case (next_class)
            NX_VALUE, NX_VALUE_OR_CLOSE: begin
                if (next_class == NX_VALUE_OR_CLOSE && (wind_down || r < 15))
                    return TK_CLOSE_ARR;
                if (!wind_down && r < 15 + open_pct)
                    return $urandom_range(1) ? TK_OPEN_OBJ : TK_OPEN_ARR;
                return scalar_tk;
            end
            NX_KEY_OR_CLOSE:   return (wind_down || r < 20) ? TK_CLOSE_OBJ : TK_STRING;
            NX_KEY:            return TK_STRING;
            NX_COLON:          return TK_COLON;
            NX_COMMA_OR_CLOSE: return (wind_down || r >= 60) ? close_tk : TK_COMMA;
            default:           return TK_END;
        endcase
    endfunction

    // One document: mostly well formed, with noise tokens at noise_pct.
    task automatic run_document(input int budget, input int open_pct, input int noise_pct);
        int              n;
        bit              doc_done;
        logic [TK_W-1:0] tk;
        n        = 0;
        doc_done = 1'b0;
        while (!doc_done) begin
            if ($urandom_range(99) < noise_pct)
                tk = TK_W'($urandom_range(TK_TOP_CODE));
            else if (err_flag && $urandom_range(99) < 30)
                tk = TK_END;
            else
                tk = pick_legal(n >= budget, open_pct);
            send_token(tk);
            n++;
            doc_done = (tk == TK_END);
        end
    endtask

    // Opens n containers of random kind, adding a key where the parent is
    // an object.
    task automatic nest_down(input int n);
        repeat (n) begin
            if (top_is_object()) begin
                send_token(TK_STRING);
                send_token(TK_COLON);
            end
            send_token($urandom_range(1) ? TK_OPEN_OBJ : TK_OPEN_ARR);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // top-level scalar completes; open array then end is premature
        send_token(TK_NUMBER);   send_token(TK_END);
        send_token(TK_OPEN_ARR); send_token(TK_END);
        // {"k": [true, null]} style, every token class
        send_token(TK_OPEN_OBJ); send_token(TK_STRING);    send_token(TK_COLON);
        send_token(TK_OPEN_ARR); send_token(TK_BOOLEAN);   send_token(TK_COMMA);
        send_token(TK_NULL);     send_token(TK_CLOSE_ARR); send_token(TK_CLOSE_OBJ);
        send_token(TK_END);
        // wrong kind of close, then a token after the error
        send_token(TK_OPEN_ARR); send_token(TK_CLOSE_OBJ); send_token(TK_NUMBER);
        send_token(TK_END);
        // comma in an object must be followed by a key, not a number
        send_token(TK_OPEN_OBJ); send_token(TK_STRING);    send_token(TK_COLON);
        send_token(TK_NULL);     send_token(TK_COMMA);     send_token(TK_NUMBER);
        send_token(TK_END);
        // unknown token is never allowed
        send_token(TK_UNKNOWN);  send_token(TK_END);
    endtask

    task automatic test_depth_limits();
        logic [DEP_W-1:0] lims[6];
        int               eff;
        lims = '{7'd1, 7'd2, LIMIT_RESET, 7'd0, 7'd65, 7'd0};
        lims[5] = DEP_W'($urandom_range(3, MAXD - 1));
        foreach (lims[i]) begin
            write_depth_limit(lims[i]);
            eff = (lims[i] > MAXD) ? MAXD : lims[i];
            // fill exactly to the limit and unwind: accepted, but a premature end at limit 0
            nest_down(eff);
            while (open_depth != 0)
                send_token(top_is_object() ? TK_CLOSE_OBJ : TK_CLOSE_ARR);
            send_token(TK_END);
            // one level past the limit: too deep, and sticky afterwards
            nest_down(eff + 1);
            send_token(TK_STRING);
            send_token(TK_END);
        end
    endtask

    task automatic test_random_traffic();
        int docs;
        int start;
        logic [DEP_W-1:0] lim;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       set_idling(0, 0);
                1:       set_idling(45, 0);
                2:       set_idling(0, 45);
                default: set_idling(12, 12);
            endcase
            docs  = 0;
            start = tokens_sent;
            while (tokens_sent - start < RANDOM_ITEMS) begin
                if (docs % 8 == 0) begin
                    // small limits dominate so overflow shows up often
                    case ($urandom_range(9))
                        0:       lim = '0;
                        1:       lim = LIMIT_RESET;
                        2:       lim = DEP_W'($urandom_range(MAXD + 1, 127));
                        3:       lim = DEP_W'($urandom_range(9, MAXD - 1));
                        default: lim = DEP_W'($urandom_range(1, 8));
                    endcase
                    write_depth_limit(lim);
                end
                if ($urandom_range(99) < 5)
                    run_document(150, 70, 0);           // occasional deep one
                else if ($urandom_range(99) < 25)
                    run_document($urandom_range(2, 24), 40, 15);
                else
                    run_document($urandom_range(2, 24), 40, 0);
                docs++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        fail_count  = 0;
        tokens_sent = 0;
        set_idling(0, 0);
        i_rst_n           <= 1'b0;
        tok_if.valid      <= 1'b0;
        tok_if.token_kind <= TK_END;
        cfg_if.valid      <= 1'b0;
        cfg_if.data       <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        clear_document();
        depth_limit_r = LIMIT_RESET;

        test_directed();
        test_depth_limits();
        test_random_traffic();
        settle();

        if (fail_count == 0 && verdict_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/jtsc_pkg.sv
rtl/jtsc_tok_if.sv
rtl/jtsc_res_if.sv
rtl/jtsc_cfg_if.sv
rtl/jtsc_front.sv
rtl/jtsc_queue.sv
rtl/jtsc_ram.sv
rtl/jtsc_back.sv
rtl/json_token_structure_check.sv
tb/testbench.sv
